// ===== design/improv_serial_frame_parser_core_macros.svh =====
// Assertion macros used by the frame parser step module.
`ifndef IMPROV_SERIAL_FRAME_PARSER_CORE_MACROS_SVH
`define IMPROV_SERIAL_FRAME_PARSER_CORE_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define ISPF_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("frame parser assertion failed");

// Next-cycle implication, checked outside of reset.
`define ISPF_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("frame parser assertion failed");

`endif

// ===== design/ispf_pkg.sv =====
// Types, constants and helper functions of the serial frame parser.
package ispf_pkg;

    localparam int unsigned MAX_FRAME_BYTES = 100;

    localparam logic [8:0] HDR_LEN     = 9'd6;
    localparam logic [8:0] POS_VERSION = 9'd6;
    localparam logic [8:0] POS_TYPE    = 9'd7;
    localparam logic [8:0] POS_LENGTH  = 9'd8;
    localparam logic [8:0] POS_PAYLOAD = 9'd9;
    localparam logic [8:0] MAX_POS     = 9'(MAX_FRAME_BYTES);

    localparam logic [7:0] VERSION_RESET  = 8'd1;
    localparam logic [7:0] RPC_TYPE_RESET = 8'd3;

    localparam logic       CFG_VERSION  = 1'b0;
    localparam logic       CFG_RPC_TYPE = 1'b1;

    typedef enum logic [2:0] {
        ST_ACCEPT   = 3'd0,
        ST_REJECT   = 3'd1,
        ST_BADSUM   = 3'd2,
        ST_RPC      = 3'd3,
        ST_OTHER    = 3'd4,
        ST_OVERFLOW = 3'd5
    } t_status;

    typedef struct packed {
        t_status    status;
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [7:0] frame_kind;
        logic [7:0] payload_length;
        logic [7:0] command_code;
        logic       command_well_formed;
    } t_result;

    // Expected ASCII character at each header position.
    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h49;
            3'd1:    c = 8'h4D;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h52;
            3'd4:    c = 8'h4F;
            3'd5:    c = 8'h56;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== design/ispf_in_reg.sv =====
// Input register that holds one received byte until the parser takes it.
module ispf_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_advance,
    output logic       o_stall,
    output logic       o_valid,
    output logic [7:0] o_byte
);
    import ispf_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       w_take;

    // The register refills in the same cycle it hands its beat on.
    assign o_stall = r_valid && !i_advance;
    assign w_take  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// ===== design/ispf_step.sv =====
// Frame state, configuration registers and the per-byte parsing logic.
module ispf_step (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_advance,
    input  logic [7:0]           i_byte,
    output ispf_pkg::t_result    o_result
);
    import ispf_pkg::*;

    logic [7:0] r_version;
    logic [7:0] r_rpc_type;

    logic [8:0] r_pos;
    logic [7:0] r_type;
    logic [7:0] r_len;
    logic [7:0] r_sum;
    logic [7:0] r_first;
    logic [7:0] r_inner;

    logic [8:0] n_pos;
    logic [7:0] n_type;
    logic [7:0] n_len;
    logic [7:0] n_sum;
    logic [7:0] n_first;
    logic [7:0] n_inner;

    logic       w_accepted;
    logic       w_finish;
    logic [9:0] w_payload_end;
    logic [8:0] w_idx;
    t_result    w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version  <= VERSION_RESET;
            r_rpc_type <= RPC_TYPE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_VERSION:  r_version  <= i_cfg_data;
                CFG_RPC_TYPE: r_rpc_type <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    assign w_payload_end = {1'b0, POS_PAYLOAD} + {2'b00, r_len};
    assign w_idx         = r_pos - POS_PAYLOAD;

    always_comb begin
        n_pos      = r_pos;
        n_type     = r_type;
        n_len      = r_len;
        n_sum      = r_sum;
        n_first    = r_first;
        n_inner    = r_inner;
        w_accepted = 1'b0;
        w_finish   = 1'b0;
        w_res      = '0;
        w_res.status = ST_ACCEPT;

        if (r_pos < HDR_LEN) begin
            w_accepted = (i_byte == hdr_char(r_pos[2:0]));
        end else if (r_pos == POS_VERSION) begin
            w_accepted = (i_byte == r_version);
        end else if (r_pos == POS_TYPE) begin
            n_type     = i_byte;
            w_accepted = 1'b1;
        end else if (r_pos == POS_LENGTH) begin
            n_len      = i_byte;
            w_accepted = 1'b1;
        end else if ({1'b0, r_pos} < w_payload_end) begin
            if (w_idx == 9'd0) begin
                n_first = i_byte;
            end
            if (w_idx == 9'd1) begin
                n_inner = i_byte;
            end
            w_res.payload_valid = 1'b1;
            w_res.payload_byte  = i_byte;
            w_res.payload_index = w_idx[7:0];
            w_accepted          = 1'b1;
        end else begin
            // Checksum byte closes the frame whatever its value.
            w_finish = 1'b1;
            if (i_byte != r_sum) begin
                w_res.status = ST_BADSUM;
            end else if (r_type == r_rpc_type) begin
                w_res.status              = ST_RPC;
                w_res.command_code        = r_first;
                w_res.command_well_formed = (r_len >= 8'd2) && (r_inner == r_len - 8'd2);
            end else begin
                w_res.status = ST_OTHER;
            end
        end

        // The result shows the frame values before any return to idle.
        w_res.frame_kind     = n_type;
        w_res.payload_length = n_len;

        if (!w_finish && w_accepted && r_pos < MAX_POS) begin
            n_sum = r_sum + i_byte;
            n_pos = r_pos + 9'd1;
        end else begin
            if (!w_finish) begin
                w_res.status = w_accepted ? ST_OVERFLOW : ST_REJECT;
            end
            n_pos   = '0;
            n_type  = '0;
            n_len   = '0;
            n_sum   = '0;
            n_first = '0;
            n_inner = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_type  <= '0;
            r_len   <= '0;
            r_sum   <= '0;
            r_first <= '0;
            r_inner <= '0;
        end else if (i_advance) begin
            r_pos   <= n_pos;
            r_type  <= n_type;
            r_len   <= n_len;
            r_sum   <= n_sum;
            r_first <= n_first;
            r_inner <= n_inner;
        end
    end

    assign o_result = w_res;

`include "improv_serial_frame_parser_core_macros.svh"

    `ISPF_ASSERT_NOW(a_pos_bound, 1'b1, r_pos <= MAX_POS)
    `ISPF_ASSERT_NOW(a_payload_pos, i_advance && w_res.payload_valid, r_pos >= POS_PAYLOAD)
    `ISPF_ASSERT_NEXT(a_idle_after_end, i_advance && w_res.status != ST_ACCEPT, r_pos == 9'd0)
    `ISPF_ASSERT_NEXT(a_pos_step, i_advance && w_res.status == ST_ACCEPT,
        r_pos == $past(r_pos) + 9'd1)

endmodule

// ===== design/ispf_out_reg.sv =====
// Result register that holds one status beat until the receiver takes it.
module ispf_out_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  ispf_pkg::t_result    i_result,
    input  logic                 i_stall,
    output logic                 o_ready,
    output logic                 o_valid,
    output ispf_pkg::t_result    o_result
);
    import ispf_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== design/improv_serial_frame_parser_core.sv =====
// Top level of the serial provisioning frame parser.
//
// Bytes enter on i_valid/i_rx_byte and are taken at an edge where o_stall is low.
// Every byte yields exactly one status beat on o_valid with its fields; it is
// taken at an edge where i_stall is low. The parsing logic works on a byte
// held in the input register; its beat is loaded into the result register
// once that register can accept it. Throughput is one byte per cycle while
// the receiver does not stall. The input register refills while the result
// register still holds an unread beat; when the receiver stalls, both
// registers fill and o_stall rises until the result is taken. The user must
// write the configuration (version byte, command frame type) through
// i_cfg_we/i_cfg_index/i_cfg_data only while the parser is idle; the block
// itself does not enforce it. Synchronous reset clears the frame state and
// both registers and restores version 1 and command type 3; no beat is in
// flight after reset.
module improv_serial_frame_parser_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_status,
    output logic       o_payload_valid,
    output logic [7:0] o_payload_byte,
    output logic [7:0] o_payload_index,
    output logic [7:0] o_frame_kind,
    output logic [7:0] o_payload_length,
    output logic [7:0] o_command_code,
    output logic       o_command_well_formed
);
    import ispf_pkg::*;

    logic       w_in_valid;
    logic [7:0] w_in_byte;
    logic       w_out_ready;
    logic       w_advance;
    t_result    w_step_res;
    t_result    w_out_res;

    assign w_advance = w_in_valid && w_out_ready;

    ispf_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_byte    (i_rx_byte),
        .i_advance (w_advance),
        .o_stall   (o_stall),
        .o_valid   (w_in_valid),
        .o_byte    (w_in_byte)
    );

    ispf_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_advance   (w_advance),
        .i_byte      (w_in_byte),
        .o_result    (w_step_res)
    );

    ispf_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance),
        .i_result (w_step_res),
        .i_stall  (i_stall),
        .o_ready  (w_out_ready),
        .o_valid  (o_valid),
        .o_result (w_out_res)
    );

    assign o_status              = w_out_res.status;
    assign o_payload_valid       = w_out_res.payload_valid;
    assign o_payload_byte        = w_out_res.payload_byte;
    assign o_payload_index       = w_out_res.payload_index;
    assign o_frame_kind          = w_out_res.frame_kind;
    assign o_payload_length      = w_out_res.payload_length;
    assign o_command_code        = w_out_res.command_code;
    assign o_command_well_formed = w_out_res.command_well_formed;

endmodule

// ===== tb/improv_serial_frame_parser_core_test.sv =====
// Self-checking testbench of the serial provisioning frame parser core.
module improv_serial_frame_parser_core_test;
    import ispf_pkg::*;

    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 80;
    localparam logic [47:0] MAGIC = "IMPROV";

    typedef enum int unsigned {
        IDLE_NONE,
        IDLE_HEAVY,
        IDLE_LIGHT
    } t_idle;

    typedef struct {
        logic [7:0]  data;
        int unsigned gap;
    } t_rx_item;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic       cfg_sel   = CFG_VERSION;
    logic [7:0] cfg_data  = 8'd0;
    logic       in_valid  = 1'b0;
    logic [7:0] in_byte   = 8'd0;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [2:0] out_status;
    logic       out_payload_valid;
    logic [7:0] out_payload_byte;
    logic [7:0] out_payload_index;
    logic [7:0] out_frame_kind;
    logic [7:0] out_payload_length;
    logic [7:0] out_command_code;
    logic       out_command_well_formed;

    // Parser state mirrored by the predictor.
    logic [8:0] frame_pos;
    logic [7:0] frame_type;
    logic [7:0] frame_len;
    logic [7:0] run_sum;
    logic [7:0] first_pl;
    logic [7:0] inner_len;
    logic [7:0] cfg_version;
    logic [7:0] cfg_rpc_type;

    t_result     parse_results[$];
    t_result     want_beat;
    t_rx_item    rx_pending[$];
    t_rx_item    cur_item;
    logic        have_item     = 1'b0;
    t_idle       tx_mode       = IDLE_NONE;
    t_idle       rx_mode       = IDLE_NONE;
    logic [7:0]  cur_version   = VERSION_RESET;
    logic [7:0]  cur_rpc       = RPC_TYPE_RESET;
    int unsigned bytes_queued  = 0;
    int unsigned bytes_taken   = 0;
    int unsigned tx_last       = 0;
    int unsigned beats_seen    = 0;
    int unsigned beats_last    = 0;
    int unsigned hold_requests = 0;
    int unsigned holds_started = 0;
    int unsigned hold_left     = 0;
    int unsigned wait_left     = 0;
    int unsigned errors        = 0;
    int unsigned quiet         = 0;

    improv_serial_frame_parser_core u_dut (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_cfg_we              (cfg_we),
        .i_cfg_index           (cfg_sel),
        .i_cfg_data            (cfg_data),
        .i_valid               (in_valid),
        .o_stall               (in_stall),
        .i_rx_byte             (in_byte),
        .o_valid               (out_valid),
        .i_stall               (out_stall),
        .o_status              (out_status),
        .o_payload_valid       (out_payload_valid),
        .o_payload_byte        (out_payload_byte),
        .o_payload_index       (out_payload_index),
        .o_frame_kind          (out_frame_kind),
        .o_payload_length      (out_payload_length),
        .o_command_code        (out_command_code),
        .o_command_well_formed (out_command_well_formed)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [7:0] magic_char(input int k);
        return MAGIC[47 - 8 * k -: 8];
    endfunction

    function automatic int unsigned draw_wait(input t_idle mode);
        case (mode)
            IDLE_NONE:  return 0;
            IDLE_HEAVY: return $urandom_range(0, 18);
            default:    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
        endcase
    endfunction

    function automatic void parser_idle();
        frame_pos  = '0;
        frame_type = '0;
        frame_len  = '0;
        run_sum    = '0;
        first_pl   = '0;
        inner_len  = '0;
    endfunction

    // Advances the mirrored parser by one byte and returns the status beat it causes.
    function automatic t_result parse_byte(input logic [7:0] b);
        t_result r;
        logic    ok;
        logic    done;
        int      p;
        int      idx;
        r    = '0;
        ok   = 1'b0;
        done = 1'b0;
        p    = int'(frame_pos);
        r.status = ST_ACCEPT;
        if (p < int'(HDR_LEN)) begin
            ok = (b == magic_char(p));
        end else if (p == int'(POS_VERSION)) begin
            ok = (b == cfg_version);
        end else if (p == int'(POS_TYPE)) begin
            frame_type = b;
            ok = 1'b1;
        end else if (p == int'(POS_LENGTH)) begin
            frame_len = b;
            ok = 1'b1;
        end else if (p < int'(POS_PAYLOAD) + int'(frame_len)) begin
            idx = p - int'(POS_PAYLOAD);
            if (idx == 0) first_pl = b;
            if (idx == 1) inner_len = b;
            r.payload_valid = 1'b1;
            r.payload_byte  = b;
            r.payload_index = 8'(idx);
            ok = 1'b1;
        end else begin
            // The checksum byte closes the frame whatever its value.
            done = 1'b1;
            if (b != run_sum) begin
                r.status = ST_BADSUM;
            end else if (frame_type == cfg_rpc_type) begin
                r.status       = ST_RPC;
                r.command_code = first_pl;
                r.command_well_formed = (frame_len >= 8'd2)
                    && (int'(inner_len) == int'(frame_len) - 2);
            end else begin
                r.status = ST_OTHER;
            end
        end
        r.frame_kind     = frame_type;
        r.payload_length = frame_len;
        if (done) begin
            parser_idle();
        end else if (!ok) begin
            r.status = ST_REJECT;
            parser_idle();
        end else if (p + 1 > int'(MAX_FRAME_BYTES)) begin
            r.status = ST_OVERFLOW;
            parser_idle();
        end else begin
            run_sum   = run_sum + b;
            frame_pos = frame_pos + 9'd1;
        end
        return r;
    endfunction

    task automatic queue_byte(input logic [7:0] b);
        t_rx_item it;
        it.data = b;
        it.gap  = draw_wait(tx_mode);
        rx_pending.insert(rx_pending.size(), it);
        bytes_queued++;
    endtask

    // A negative fill draws every payload byte at random, apart from the inner length byte when fix_inner is set.
    task automatic queue_frame(input logic [7:0] ftype, input int unsigned len,
                               input bit fix_inner, input bit bad_sum, input int fill);
        logic [7:0] sum;
        logic [7:0] b;
        sum = 8'd0;
        for (int k = 0; k < 6; k++) begin
            queue_byte(magic_char(k));
            sum += magic_char(k);
        end
        queue_byte(cur_version);
        queue_byte(ftype);
        queue_byte(8'(len));
        sum += cur_version + ftype + 8'(len);
        for (int k = 0; k < int'(len); k++) begin
            b = (fill < 0) ? 8'($urandom) : 8'(fill);
            if (k == 1 && fix_inner) b = 8'(len - 2);
            queue_byte(b);
            sum += b;
        end
        if (bad_sum) sum += 8'($urandom_range(1, 255));
        queue_byte(sum);
    endtask

    // Sends a correct prefix of the given length and then a wrong header or version byte.
    task automatic queue_broken(input int unsigned at);
        logic [7:0] good;
        for (int k = 0; k < int'(at); k++)
            queue_byte((k < 6) ? magic_char(k) : cur_version);
        good = (at < 6) ? magic_char(at) : cur_version;
        queue_byte(good ^ 8'($urandom_range(1, 255)));
    endtask

    task automatic queue_random(input int unsigned count);
        int unsigned stop;
        int unsigned pick;
        int unsigned len;
        stop = bytes_queued + count;
        while (bytes_queued < stop) begin
            pick = $urandom_range(0, 19);
            if (pick < 12) begin
                len = ($urandom_range(0, 39) == 0) ? $urandom_range(85, 120)
                                                   : $urandom_range(0, 8);
                queue_frame(($urandom_range(0, 1) != 0) ? cur_rpc : 8'($urandom), len,
                            1'($urandom_range(0, 1)), ($urandom_range(0, 9) == 0), -1);
            end else if (pick < 16) begin
                queue_broken($urandom_range(0, 6));
            end else begin
                repeat ($urandom_range(1, 4)) queue_byte(8'($urandom));
            end
        end
    endtask

    task automatic wait_for_drain();
        do @(posedge clk);
        while (rx_pending.size() != 0 || have_item || in_valid || parse_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] version, input logic [7:0] rpc_type);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_sel  <= CFG_VERSION;
        cfg_data <= version;
        @(negedge clk);
        cfg_sel  <= CFG_RPC_TYPE;
        cfg_data <= rpc_type;
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_version = version;
        cur_rpc     = rpc_type;
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= 10)
                $display("beat %0d %s: expected %0d, got %0d", beats_seen, name, want, got);
        end
    endtask

    // Predictor side of the driver: mirrors config writes and every accepted byte.
    always @(posedge clk) begin
        if (!rst_n) begin
            parser_idle();
            cfg_version  = VERSION_RESET;
            cfg_rpc_type = RPC_TYPE_RESET;
        end else begin
            if (cfg_we) begin
                case (cfg_sel)
                    CFG_VERSION:  cfg_version  = cfg_data;
                    CFG_RPC_TYPE: cfg_rpc_type = cfg_data;
                endcase
            end
            if (in_valid && !in_stall) begin
                parse_results.insert(parse_results.size(), parse_byte(in_byte));
                bytes_taken <= bytes_taken + 1;
            end
        end
    end

    // A beat that is still offered and not yet taken is held unchanged.
    always @(negedge clk) begin
        if (rst_n && !(in_valid && bytes_taken == tx_last)) begin
            tx_last = bytes_taken;
            if (!have_item && rx_pending.size() > 0) begin
                cur_item  = rx_pending.pop_front();
                have_item = 1'b1;
            end
            if (have_item && cur_item.gap == 0) begin
                in_valid  <= 1'b1;
                in_byte   <= cur_item.data;
                have_item = 1'b0;
            end else begin
                in_valid <= 1'b0;
                if (have_item) cur_item.gap--;
            end
        end
    end

    always @(negedge clk) begin
        if (rst_n) begin
            if (holds_started != hold_requests) begin
                holds_started = hold_requests;
                hold_left     = HOLD_CYCLES;
            end
            if (beats_seen != beats_last) begin
                beats_last = beats_seen;
                wait_left  = draw_wait(rx_mode);
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (wait_left > 0) begin
                wait_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            beats_seen <= beats_seen + 1;
            if (parse_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat %0d, status %0d", beats_seen, out_status);
            end else begin
                want_beat = parse_results.pop_front();
                check_field("status", 8'(want_beat.status), 8'(out_status));
                check_field("payload_valid", 8'(want_beat.payload_valid),
                            8'(out_payload_valid));
                check_field("payload_byte", want_beat.payload_byte, out_payload_byte);
                check_field("payload_index", want_beat.payload_index, out_payload_index);
                check_field("frame_kind", want_beat.frame_kind, out_frame_kind);
                check_field("payload_length", want_beat.payload_length, out_payload_length);
                check_field("command_code", want_beat.command_code, out_command_code);
                check_field("command_well_formed", 8'(want_beat.command_well_formed),
                            8'(out_command_well_formed));
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed frames under the reset configuration, no idling on either side.
        queue_frame(cur_rpc, 2, 1'b1, 1'b0, -1);
        queue_frame(cur_rpc, 0, 1'b0, 1'b0, -1);
        queue_frame(cur_rpc, 1, 1'b1, 1'b0, -1);
        queue_frame(cur_rpc, 5, 1'b0, 1'b0, -1);
        queue_frame(8'h00, 3, 1'b0, 1'b0, 8'hff);
        queue_frame(cur_rpc, 2, 1'b1, 1'b1, -1);
        for (int k = 0; k <= 6; k++) queue_broken(k);
        // A restart inside the header is rejected, not taken as a new frame start.
        queue_byte(magic_char(0));
        queue_byte(magic_char(1));
        queue_byte(magic_char(2));
        queue_frame(cur_rpc, 2, 1'b1, 1'b0, -1);
        queue_frame(cur_rpc, 3, 1'b1, 1'b0, -1);
        // Longest frame that fits, then one whose payload runs past the buffer limit.
        queue_frame(8'h7e, 91, 1'b0, 1'b0, 8'h00);
        queue_frame(8'hff, 255, 1'b0, 1'b0, 8'hff);
        wait_for_drain();

        set_config(8'h00, 8'hff);
        tx_mode = IDLE_NONE;
        rx_mode = IDLE_HEAVY;
        hold_requests++;
        queue_random(40);
        tx_mode = IDLE_HEAVY;
        queue_random(70);
        wait_for_drain();

        set_config(8'hff, 8'h00);
        tx_mode = IDLE_LIGHT;
        rx_mode = IDLE_LIGHT;
        queue_random(100);
        wait_for_drain();

        set_config(8'($urandom), 8'($urandom));
        tx_mode = IDLE_NONE;
        rx_mode = IDLE_NONE;
        hold_requests++;
        queue_random(40);
        tx_mode = IDLE_HEAVY;
        queue_random(70);
        wait_for_drain();

        set_config(VERSION_RESET, RPC_TYPE_RESET);
        tx_mode = IDLE_LIGHT;
        rx_mode = IDLE_HEAVY;
        queue_random(100);
        wait_for_drain();

        if (errors == 0 && parse_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/ispf_pkg.sv
design/ispf_in_reg.sv
design/ispf_step.sv
design/ispf_out_reg.sv
design/improv_serial_frame_parser_core.sv
tb/improv_serial_frame_parser_core_test.sv
